// File: sv/scbp_pkg.sv
package scbp_pkg;

  // Pool geometry
  localparam int unsigned CLASSES        = 24;
  localparam int unsigned MIN_CLASS_LOG2 = 20;
  localparam int unsigned STACK_DEPTH    = 8;

  // Field widths
  localparam int unsigned BytesW = 48;
  localparam int unsigned ClsW   = 5;
  localparam int unsigned FillW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned MemDepth = CLASSES * STACK_DEPTH;
  localparam int unsigned AddrW  = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  typedef logic [BytesW-1:0]  bytes_t;
  typedef logic [ClsW-1:0]    cls_t;
  typedef logic [CLASSES-1:0] cmask_t;
  typedef logic [FillW-1:0]   fill_t;
  typedef logic [AddrW-1:0]   addr_t;

  typedef enum logic [1:0] {
    ACT_TAKE  = 2'd0,
    ACT_GIVE  = 2'd1,
    ACT_TRIM  = 2'd2,
    ACT_QUERY = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_FRESH     = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_KEPT      = 3'd3,
    ST_RELEASE   = 3'd4,
    ST_TRIMMED   = 3'd5,
    ST_TRIM_DONE = 3'd6,
    ST_QUERY     = 3'd7
  } status_e;

  // Command to the stack store
  typedef struct packed {
    logic   push;
    logic   pop;
    cls_t   cls;
    bytes_t wdata;
  } stk_cmd_t;

  // Class mapping of the latched request and capacity
  typedef struct packed {
    cls_t req_cls;
    logic req_too_large;
    cls_t cap_cls;
    logic cap_exact;
  } cls_map_t;

  // Result of a priority search over class flags
  typedef struct packed {
    logic found;
    cls_t idx;
  } find_t;

  // Operands of the shared adder
  typedef struct packed {
    bytes_t a;
    bytes_t b;
    logic   sub;
  } alu_op_t;

  function automatic bytes_t class_size(input cls_t c);
    class_size = bytes_t'(1) << (MIN_CLASS_LOG2 + int'(c));
  endfunction

  // Lowest set flag at or above a start class
  function automatic find_t first_set_from(input cmask_t m, input cls_t from);
    find_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = CLASSES - 1; i >= 0; i--) begin
      if (m[i] && (ClsW'(i) >= from)) begin
        r.found = 1'b1;
        r.idx   = ClsW'(i);
      end
    end
    return r;
  endfunction

  // Highest set flag
  function automatic find_t last_set(input cmask_t m);
    find_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = 0; i < CLASSES; i++) begin
      if (m[i]) begin
        r.found = 1'b1;
        r.idx   = ClsW'(i);
      end
    end
    return r;
  endfunction

  function automatic addr_t slot_addr(input cls_t c, input fill_t s);
    slot_addr = addr_t'(c) * addr_t'(STACK_DEPTH) + addr_t'(s);
  endfunction

endpackage

// File: sv/scbp_in_if.sv
interface scbp_in_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  scbp_pkg::bytes_t      request_bytes;
  scbp_pkg::bytes_t      block_handle;
  scbp_pkg::bytes_t      block_capacity;

  modport source (
    output valid, action, request_bytes, block_handle, block_capacity,
    input  ready
  );
  modport sink (
    input  valid, action, request_bytes, block_handle, block_capacity,
    output ready
  );
endinterface

// File: sv/scbp_out_if.sv
interface scbp_out_if;
  logic                  valid;
  logic                  ready;
  logic [2:0]            status;
  scbp_pkg::bytes_t      out_handle;
  scbp_pkg::bytes_t      capacity_bytes;
  scbp_pkg::cls_t        class_found;
  logic                  class_valid;
  scbp_pkg::bytes_t      pooled_now;

  modport source (
    output valid, status, out_handle, capacity_bytes, class_found, class_valid,
           pooled_now,
    input  ready
  );
  modport sink (
    input  valid, status, out_handle, capacity_bytes, class_found, class_valid,
           pooled_now,
    output ready
  );
endinterface

// File: sv/size_class_block_pool_unit.sv
// Block pool with one LIFO stack of handles per power-of-two size class and a
// pooled-byte count held under budget_bytes. One item is processed at a time:
// in_chan_i.ready is high only while the sequencer is idle. A take that hits,
// a kept give-back and a trim that releases a block go through the headroom,
// decide, count update and result steps after the transfer; the other cases
// skip the count update. The single 48-bit adder/subtractor computes budget
// minus pooled bytes, then the give-back fit check, then the pooled-count
// update; the read of the handle memory is registered. A finished result
// waits in the output register while the next item is being worked on.
// The user writes budget_bytes through cfg_we_i/cfg_wdata_i while the block
// is idle; the block does not enforce this. A write never trims by itself.
module size_class_block_pool_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  scbp_pkg::bytes_t cfg_wdata_i,
  scbp_in_if.sink          in_chan_i,
  scbp_out_if.source       out_chan_o
);
  import scbp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_HEAD   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_UPD    = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration and pool count
  bytes_t budget_q;
  bytes_t pooled_q, pooled_d;

  // Latched item
  action_e act_q;
  bytes_t  req_q, handle_q, cap_q;

  // Working values
  cls_map_t map, map_q;
  bytes_t   head_q;
  logic     head_neg_q;
  cls_t     upd_cls_q, upd_cls_d;
  logic     upd_sub_q, upd_sub_d;

  // Result held until the output register is free
  status_e res_status_q, res_status_d;
  logic    res_mem_q, res_mem_d;
  bytes_t  res_cap_q, res_cap_d;
  cls_t    res_cls_q, res_cls_d;
  logic    res_valid_q, res_valid_d;

  // Output register
  logic    out_valid_q;
  status_e out_status_q;
  bytes_t  out_handle_q, out_cap_q, out_pooled_q;
  cls_t    out_cls_q;
  logic    out_cvalid_q;
  logic    out_load;

  // Shared adder and store
  alu_op_t  alu_op;
  bytes_t   alu_res;
  logic     alu_borrow;
  stk_cmd_t stk_cmd;
  cmask_t   nonempty, full, over, query_mask;
  bytes_t   stk_rdata;
  find_t    up_f, top_f, query_f;

  scbp_alu u_alu (
    .op_i     (alu_op),
    .res_o    (alu_res),
    .borrow_o (alu_borrow)
  );

  scbp_class_map u_map (
    .req_i (req_q),
    .cap_i (cap_q),
    .map_o (map)
  );

  scbp_stacks u_stacks (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (stk_cmd),
    .nonempty_o (nonempty),
    .full_o     (full),
    .rdata_o    (stk_rdata)
  );

  // Priority searches over the class flags
  always_comb begin
    for (int i = 0; i < CLASSES; i++) begin
      over[i] = head_neg_q | (class_size(ClsW'(i)) > head_q);
    end
  end

  assign query_mask = ~nonempty & ~over;
  assign up_f       = first_set_from(nonempty, map_q.req_cls);
  assign top_f      = last_set(nonempty);
  assign query_f    = first_set_from(query_mask, '0);

  // Shared adder operand select
  always_comb begin
    alu_op.a   = head_q;
    alu_op.b   = cap_q;
    alu_op.sub = 1'b1;
    unique case (state_q)
      S_HEAD: begin
        alu_op.a = budget_q;
        alu_op.b = pooled_q;
      end
      S_UPD: begin
        alu_op.a   = pooled_q;
        alu_op.b   = class_size(upd_cls_q);
        alu_op.sub = upd_sub_q;
      end
      default: begin
      end
    endcase
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_chan_o.ready);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    pooled_d     = pooled_q;
    upd_cls_d    = upd_cls_q;
    upd_sub_d    = upd_sub_q;
    res_status_d = res_status_q;
    res_mem_d    = res_mem_q;
    res_cap_d    = res_cap_q;
    res_cls_d    = res_cls_q;
    res_valid_d  = res_valid_q;
    stk_cmd.push  = 1'b0;
    stk_cmd.pop   = 1'b0;
    stk_cmd.cls   = '0;
    stk_cmd.wdata = handle_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_chan_i.valid) begin
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        res_status_d = ST_QUERY;
        res_mem_d    = 1'b0;
        res_cap_d    = '0;
        res_cls_d    = '0;
        res_valid_d  = 1'b0;
        state_d      = S_DONE;
        unique case (act_q)
          ACT_TAKE: begin
            if (map_q.req_too_large) begin
              res_status_d = ST_TOO_LARGE;
            end else if (up_f.found) begin
              stk_cmd.pop  = 1'b1;
              stk_cmd.cls  = up_f.idx;
              res_status_d = ST_HIT;
              res_mem_d    = 1'b1;
              res_cap_d    = class_size(up_f.idx);
              res_cls_d    = up_f.idx;
              res_valid_d  = 1'b1;
              upd_cls_d    = up_f.idx;
              upd_sub_d    = 1'b1;
              state_d      = S_UPD;
            end else begin
              res_status_d = ST_FRESH;
              res_cap_d    = class_size(map_q.req_cls);
              res_cls_d    = map_q.req_cls;
              res_valid_d  = 1'b1;
            end
          end
          ACT_GIVE: begin
            if ((handle_q != '0) && map_q.cap_exact && !head_neg_q && !alu_borrow &&
                !full[map_q.cap_cls]) begin
              stk_cmd.push = 1'b1;
              stk_cmd.cls  = map_q.cap_cls;
              res_status_d = ST_KEPT;
              res_cls_d    = map_q.cap_cls;
              res_valid_d  = 1'b1;
              upd_cls_d    = map_q.cap_cls;
              upd_sub_d    = 1'b0;
              state_d      = S_UPD;
            end else begin
              res_status_d = ST_RELEASE;
            end
          end
          ACT_TRIM: begin
            if (head_neg_q && top_f.found) begin
              stk_cmd.pop  = 1'b1;
              stk_cmd.cls  = top_f.idx;
              res_status_d = ST_TRIMMED;
              res_mem_d    = 1'b1;
              res_cls_d    = top_f.idx;
              res_valid_d  = 1'b1;
              upd_cls_d    = top_f.idx;
              upd_sub_d    = 1'b1;
              state_d      = S_UPD;
            end else begin
              res_status_d = ST_TRIM_DONE;
            end
          end
          ACT_QUERY: begin
            if (query_f.found) begin
              res_cap_d   = class_size(query_f.idx);
              res_cls_d   = query_f.idx;
              res_valid_d = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_UPD: begin
        pooled_d = alu_res;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_chan_i.ready = (state_q == S_IDLE);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      budget_q    <= '0;
      pooled_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pooled_q <= pooled_d;
      if (cfg_we_i) begin
        budget_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_chan_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item, working and result registers
  always_ff @(posedge clk_i) begin
    if (in_chan_i.valid && in_chan_i.ready) begin
      act_q    <= action_e'(in_chan_i.action);
      req_q    <= in_chan_i.request_bytes;
      handle_q <= in_chan_i.block_handle;
      cap_q    <= in_chan_i.block_capacity;
    end
    if (state_q == S_HEAD) begin
      head_q     <= alu_res;
      head_neg_q <= alu_borrow;
      map_q      <= map;
    end
    upd_cls_q    <= upd_cls_d;
    upd_sub_q    <= upd_sub_d;
    res_status_q <= res_status_d;
    res_mem_q    <= res_mem_d;
    res_cap_q    <= res_cap_d;
    res_cls_q    <= res_cls_d;
    res_valid_q  <= res_valid_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_handle_q <= res_mem_q ? stk_rdata : '0;
      out_cap_q    <= res_cap_q;
      out_cls_q    <= res_cls_q;
      out_cvalid_q <= res_valid_q;
      out_pooled_q <= pooled_q;
    end
  end

  assign out_chan_o.valid          = out_valid_q;
  assign out_chan_o.status         = out_status_q;
  assign out_chan_o.out_handle     = out_handle_q;
  assign out_chan_o.capacity_bytes = out_cap_q;
  assign out_chan_o.class_found    = out_cls_q;
  assign out_chan_o.class_valid    = out_cvalid_q;
  assign out_chan_o.pooled_now     = out_pooled_q;

endmodule

// File: sv/scbp_alu.sv
module scbp_alu (
  input  scbp_pkg::alu_op_t op_i,
  output scbp_pkg::bytes_t  res_o,
  output logic              borrow_o
);
  import scbp_pkg::*;

  logic [BytesW:0] sum;

  // Shared add / subtract; top bit is the borrow on subtract
  always_comb begin
    if (op_i.sub) begin
      sum = {1'b0, op_i.a} - {1'b0, op_i.b};
    end else begin
      sum = {1'b0, op_i.a} + {1'b0, op_i.b};
    end
  end

  assign res_o    = sum[BytesW-1:0];
  assign borrow_o = op_i.sub & sum[BytesW];

endmodule

// File: sv/scbp_class_map.sv
module scbp_class_map (
  input  scbp_pkg::bytes_t   req_i,
  input  scbp_pkg::bytes_t   cap_i,
  output scbp_pkg::cls_map_t map_o
);
  import scbp_pkg::*;

  cmask_t fits;
  cmask_t exact;
  find_t  fit_f;
  find_t  exact_f;

  // Per-class compares against the constant class sizes
  always_comb begin
    for (int i = 0; i < CLASSES; i++) begin
      fits[i]  = (req_i <= class_size(ClsW'(i)));
      exact[i] = (cap_i == class_size(ClsW'(i)));
    end
  end

  assign fit_f   = first_set_from(fits, '0);
  assign exact_f = first_set_from(exact, '0);

  assign map_o.req_cls       = fit_f.idx;
  assign map_o.req_too_large = ~fit_f.found;
  assign map_o.cap_cls       = exact_f.idx;
  assign map_o.cap_exact     = exact_f.found;

endmodule

// File: sv/scbp_stacks.sv
module scbp_stacks (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scbp_pkg::stk_cmd_t cmd_i,
  output scbp_pkg::cmask_t   nonempty_o,
  output scbp_pkg::cmask_t   full_o,
  output scbp_pkg::bytes_t   rdata_o
);
  import scbp_pkg::*;

  bytes_t mem [MemDepth];
  bytes_t rdata_q;
  fill_t  fill_q [CLASSES];
  fill_t  fill_d [CLASSES];
  fill_t  cur_fill;
  fill_t  top_slot;

  assign cur_fill = fill_q[cmd_i.cls];
  assign top_slot = cur_fill - fill_t'(1);

  // Handle store: push writes at the fill level, pop reads the top entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[slot_addr(cmd_i.cls, cur_fill)] <= cmd_i.wdata;
    end
    if (cmd_i.pop) begin
      rdata_q <= mem[slot_addr(cmd_i.cls, top_slot)];
    end
  end

  // Fill counters
  always_comb begin
    for (int i = 0; i < CLASSES; i++) begin
      fill_d[i] = fill_q[i];
      if (cmd_i.cls == ClsW'(i)) begin
        if (cmd_i.push) begin
          fill_d[i] = fill_q[i] + fill_t'(1);
        end else if (cmd_i.pop) begin
          fill_d[i] = fill_q[i] - fill_t'(1);
        end
      end
      nonempty_o[i] = (fill_q[i] != '0);
      full_o[i]     = (fill_q[i] == fill_t'(STACK_DEPTH));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CLASSES; i++) begin
        fill_q[i] <= '0;
      end
    end else begin
      fill_q <= fill_d;
    end
  end

  assign rdata_o = rdata_q;

endmodule
